// ----- rtl/bqd_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the block dequantiser
// no dependencies

package bqd_pkg;

    localparam int LANES               = 4;
    localparam int DEF_MAX_BLOCK_BYTES = 210;

    localparam logic [3:0] FMT_Q4_0 = 4'd0;
    localparam logic [3:0] FMT_Q4_1 = 4'd1;
    localparam logic [3:0] FMT_Q5_0 = 4'd2;
    localparam logic [3:0] FMT_Q5_1 = 4'd3;
    localparam logic [3:0] FMT_Q8_0 = 4'd4;
    localparam logic [3:0] FMT_Q8_1 = 4'd5;
    localparam logic [3:0] FMT_Q2_K = 4'd6;
    localparam logic [3:0] FMT_Q6_K = 4'd7;
    localparam logic [3:0] FMT_F16  = 4'd8;

    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_ONE  = 32'h3F80_0000;

    typedef struct packed {
        logic [7:0] byte_hi;
        logic [7:0] byte_lo;
    } bqd_in_t;

    typedef struct packed {
        logic [31:0] lane0;
        logic [31:0] lane1;
        logic [31:0] lane2;
        logic [31:0] lane3;
        logic [7:0]  element_index;
        logic [2:0]  lanes_valid;
        logic        last;
    } bqd_out_t;

    // operands for one lane: (a*b)[*c] [+ z1*z2]
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] z1;
        logic [31:0] z2;
        logic        use_mul2;
        logic        use_add;
    } lane_op_t;

    typedef struct packed {
        logic [7:0] element_index;
        logic [2:0] lanes_valid;
        logic       last;
    } res_meta_t;

endpackage

// ----- rtl/bqd_store.sv -----
`timescale 1ns / 1ps
// block byte store, 16-bit words, one write and one registered read port
// no dependencies

module bqd_store #(
    parameter int MAX_BLOCK_BYTES = 210,
    parameter int AW              = $clog2(MAX_BLOCK_BYTES / 2)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);
    localparam int DEPTH = MAX_BLOCK_BYTES / 2;

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bqd_lane.sv -----
`timescale 1ns / 1ps
// one binary32 lane: multiply, optional second multiply, optional add
// depends on bqd_pkg

module bqd_lane (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              go,
    input  bqd_pkg::lane_op_t op,
    output logic              done,
    output logic [31:0]       res
);
    import bqd_pkg::*;

    typedef struct packed {
        logic        special;
        logic [31:0] spec_val;
        logic        sign;
        logic [7:0]  exp;
        logic [27:0] sum;
    } add_mid_t;

    function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
        logic               sr;
        logic [47:0]        prod;
        logic signed [9:0]  er;
        logic [23:0]        mant;
        logic               g;
        logic               st;
        logic [24:0]        rnd;
        logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [31:0]        r;
        sr     = a[31] ^ b[31];
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = (a[30:23] == 8'd0);
        zero_b = (b[30:23] == 8'd0);
        prod   = {1'b1, a[22:0]} * {1'b1, b[22:0]};
        er     = $signed({2'b00, a[30:23]}) + $signed({2'b00, b[30:23]}) - 10'sd127;
        if (prod[47]) begin
            mant = prod[47:24];
            g    = prod[23];
            st   = |prod[22:0];
            er   = er + 10'sd1;
        end else begin
            mant = prod[46:23];
            g    = prod[22];
            st   = |prod[21:0];
        end
        rnd = {1'b0, mant} + {24'd0, g & (st | mant[0])};
        if (rnd[24]) begin
            mant = rnd[24:1];
            er   = er + 10'sd1;
        end else begin
            mant = rnd[23:0];
        end
        if (nan_a || nan_b) begin
            r = F32_QNAN;
        end else if (inf_a || inf_b) begin
            r = (zero_a || zero_b) ? F32_QNAN : {sr, 8'hFF, 23'd0};
        end else if (zero_a || zero_b) begin
            r = {sr, 31'd0};
        end else if (er >= 10'sd255) begin
            r = {sr, 8'hFF, 23'd0};
        end else if (er <= 10'sd0) begin
            r = {sr, 31'd0};
        end else begin
            r = {sr, er[7:0], mant[22:0]};
        end
        return r;
    endfunction

    function automatic add_mid_t add_align(input logic [31:0] a, input logic [31:0] b);
        add_mid_t    r;
        logic [31:0] big, sml;
        logic [7:0]  diff;
        logic [26:0] mb, ms, ms_sh, mask;
        logic [27:0] sum;
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        r      = '0;
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = (a[30:23] == 8'd0);
        zero_b = (b[30:23] == 8'd0);
        if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
        end else begin
            big = b;
            sml = a;
        end
        diff = big[30:23] - sml[30:23];
        mb   = {1'b1, big[22:0], 3'b000};
        ms   = {1'b1, sml[22:0], 3'b000};
        mask = ~(27'h7FF_FFFF << diff);
        if (diff >= 8'd27) begin
            ms_sh = 27'd1;
        end else begin
            ms_sh = (ms >> diff) | {26'd0, |(ms & mask)};
        end
        if (big[31] == sml[31]) begin
            sum = {1'b0, mb} + {1'b0, ms_sh};
        end else begin
            sum = {1'b0, mb} - {1'b0, ms_sh};
        end
        r.special = 1'b1;
        if (nan_a || nan_b) begin
            r.spec_val = F32_QNAN;
        end else if (inf_a && inf_b) begin
            r.spec_val = (a[31] != b[31]) ? F32_QNAN : a;
        end else if (inf_a) begin
            r.spec_val = a;
        end else if (inf_b) begin
            r.spec_val = b;
        end else if (zero_a && zero_b) begin
            r.spec_val = {a[31] & b[31], 31'd0};
        end else if (zero_a) begin
            r.spec_val = b;
        end else if (zero_b) begin
            r.spec_val = a;
        end else if (sum == 28'd0) begin
            r.spec_val = 32'd0;
        end else begin
            r.special = 1'b0;
            r.sign    = big[31];
            r.exp     = big[30:23];
            r.sum     = sum;
        end
        return r;
    endfunction

    function automatic logic [31:0] add_round(input add_mid_t m);
        logic [26:0]       v;
        logic signed [9:0] e;
        logic [4:0]        lz;
        logic              found;
        logic              up;
        logic [24:0]       rnd;
        logic [23:0]       mant;
        logic [31:0]       r;
        e     = $signed({2'b00, m.exp});
        lz    = '0;
        found = 1'b0;
        if (m.sum[27]) begin
            v = {m.sum[27:2], m.sum[1] | m.sum[0]};
            e = e + 10'sd1;
        end else begin
            for (int k = 26; k >= 0; k--) begin
                if (!found && m.sum[k]) begin
                    lz    = 5'(26 - k);
                    found = 1'b1;
                end
            end
            v = m.sum[26:0] << lz;
            e = e - $signed({5'd0, lz});
        end
        up  = v[2] & (v[1] | v[0] | v[3]);
        rnd = {1'b0, v[26:3]} + {24'd0, up};
        if (rnd[24]) begin
            mant = rnd[24:1];
            e    = e + 10'sd1;
        end else begin
            mant = rnd[23:0];
        end
        if (m.special) begin
            r = m.spec_val;
        end else if (e >= 10'sd255) begin
            r = {m.sign, 8'hFF, 23'd0};
        end else if (e <= 10'sd0) begin
            r = {m.sign, 31'd0};
        end else begin
            r = {m.sign, e[7:0], mant[22:0]};
        end
        return r;
    endfunction

    logic [3:0]  vld_reg, vld_next;
    logic [31:0] p1_reg, z1_reg, c_reg, p2_reg, z2_reg, res_reg;
    logic        mul2_reg, add1_reg, add2_reg;
    add_mid_t    mid_reg;

    assign vld_next = {vld_reg[2:0], go};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg   <= f32_mul(op.a, op.b);
        z1_reg   <= f32_mul(op.z1, op.z2);
        c_reg    <= op.c;
        mul2_reg <= op.use_mul2;
        add1_reg <= op.use_add;
        p2_reg   <= mul2_reg ? f32_mul(p1_reg, c_reg) : p1_reg;
        z2_reg   <= z1_reg;
        add2_reg <= add1_reg;
        if (add2_reg) begin
            mid_reg <= add_align(p2_reg, z2_reg);
        end else begin
            mid_reg <= '{special: 1'b1, spec_val: p2_reg, sign: 1'b0, exp: 8'd0, sum: 28'd0};
        end
        res_reg <= add_round(mid_reg);
    end

    assign done = vld_reg[3];
    assign res  = res_reg;

endmodule

// ----- rtl/bqd_merge.sv -----
`timescale 1ns / 1ps
// merges lane results into one output request with an output register
// depends on bqd_pkg

module bqd_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bqd_pkg::LANES-1:0]         lane_done,
    input  logic [bqd_pkg::LANES-1:0][31:0]   lane_res,
    input  bqd_pkg::res_meta_t                meta,
    output logic                              out_free,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bqd_pkg::bqd_out_t                 m_data
);
    import bqd_pkg::*;

    logic        valid_reg, valid_next;
    bqd_out_t    data_reg;
    logic [31:0] fixed [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (3'(i) >= meta.lanes_valid) begin
                fixed[i] = 32'd0;
            end else if (lane_res[i][30:23] == 8'hFF && lane_res[i][22:0] != 23'd0) begin
                fixed[i] = F32_QNAN;
            end else begin
                fixed[i] = lane_res[i];
            end
        end
    end

    assign valid_next = (&lane_done) | (valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (&lane_done) begin
            data_reg.lane0         <= fixed[0];
            data_reg.lane1         <= fixed[1];
            data_reg.lane2         <= fixed[2];
            data_reg.lane3         <= fixed[3];
            data_reg.element_index <= meta.element_index;
            data_reg.lanes_valid   <= meta.lanes_valid;
            data_reg.last          <= meta.last;
        end
    end

    assign out_free = ~valid_reg;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

endmodule

// ----- rtl/block_quant_dequantizer.sv -----
`timescale 1ns / 1ps
// block dequantiser top: byte intake, fetch sequencer, lanes and merge
// depends on bqd_pkg, bqd_store, bqd_lane, bqd_merge
// input: one request per cycle while a block loads and cfg_valid is low; none taken while results go out
// results: each set by eight word reads on the single store read port; each waits for a free output register
// first result: after the final request, the fetch, drain and issue states, lane stages and merge register
// reset (aresetn low, synchronous) clears control state; the store is not cleared

module block_quant_dequantizer #(
    parameter int MAX_BLOCK_BYTES = bqd_pkg::DEF_MAX_BLOCK_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bqd_pkg::bqd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bqd_pkg::bqd_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_data
);
    import bqd_pkg::*;

    localparam int AW = $clog2(MAX_BLOCK_BYTES / 2);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_ISSUE = 2'd3;

    function automatic logic [8:0] blk_bytes(input logic [3:0] fmt);
        logic [8:0] r;
        case (fmt)
            FMT_Q4_0: r = 9'd18;
            FMT_Q4_1: r = 9'd20;
            FMT_Q5_0: r = 9'd22;
            FMT_Q5_1: r = 9'd24;
            FMT_Q8_0: r = 9'd34;
            FMT_Q8_1: r = 9'd36;
            FMT_Q2_K: r = 9'd84;
            FMT_Q6_K: r = 9'd210;
            FMT_F16:  r = 9'd2;
            default:  r = 9'd2;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] blk_elems(input logic [3:0] fmt);
        logic [8:0] r;
        case (fmt)
            FMT_Q2_K: r = 9'd256;
            FMT_Q6_K: r = 9'd256;
            FMT_F16:  r = 9'd1;
            default:  r = 9'd32;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] fetch_addr(input logic [3:0] fmt, input logic [7:0] e,
                                              input logic [2:0] slot);
        logic [6:0] base;
        logic [6:0] a;
        case (fmt)
            FMT_Q4_0: base = 7'd1 + {4'd0, e[3:1]};
            FMT_Q4_1: base = 7'd2 + {4'd0, e[3:1]};
            FMT_Q5_0: base = 7'd3 + {4'd0, e[3:1]};
            FMT_Q5_1: base = 7'd4 + {4'd0, e[3:1]};
            FMT_Q8_0: base = 7'd1 + {3'd0, e[4:1]};
            FMT_Q8_1: base = 7'd2 + {3'd0, e[4:1]};
            FMT_Q2_K: base = 7'd8 + {2'd0, e[7], e[4], e[3:1]};
            FMT_Q6_K: base = {1'b0, e[7], e[5], e[4:1]};
            default:  base = 7'd0;
        endcase
        case (slot)
            3'd0: a = (fmt == FMT_Q2_K) ? 7'd40 : ((fmt == FMT_Q6_K) ? 7'd104 : 7'd0);
            3'd1: a = (fmt == FMT_Q2_K) ? 7'd41 : 7'd1;
            3'd2: a = (fmt == FMT_Q5_0) ? 7'd1 : ((fmt == FMT_Q5_1) ? 7'd2 :
                      ((fmt == FMT_Q6_K) ? 7'd96 + {4'd0, e[7], e[6:5]} : 7'd0));
            3'd3: a = (fmt == FMT_Q5_0) ? 7'd2 : ((fmt == FMT_Q5_1) ? 7'd3 : 7'd0);
            3'd4: a = base;
            3'd5: a = base + 7'd1;
            3'd6: a = (fmt == FMT_Q2_K) ? {4'd0, e[7], e[6:5]} :
                      ((fmt == FMT_Q6_K) ? 7'd64 + {2'd0, e[7], e[4:1]} : 7'd0);
            3'd7: a = (fmt == FMT_Q6_K) ? 7'd65 + {2'd0, e[7], e[4:1]} : 7'd0;
            default: a = 7'd0;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic [3:0]  p;
        logic [31:0] sh;
        logic [31:0] r;
        p  = '0;
        sh = '0;
        if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0) begin
                r = {h[15], 31'd0};
            end else begin
                for (int k = 0; k < 10; k++) begin
                    if (h[k]) begin
                        p = 4'(k);
                    end
                end
                sh = {22'd0, h[9:0]} << (5'd23 - {1'b0, p});
                r  = {h[15], 8'd103 + {4'd0, p}, sh[22:0]};
            end
        end else if (h[14:10] == 5'd31) begin
            r = {h[15], 8'hFF, h[9:0] != 10'd0, 22'd0};
        end else begin
            r = {h[15], {3'd0, h[14:10]} + 8'd112, h[9:0], 13'd0};
        end
        return r;
    endfunction

    function automatic logic [31:0] int_to_f32(input logic signed [8:0] x);
        logic [8:0]  mag;
        logic [3:0]  p;
        logic [31:0] sh;
        logic [31:0] r;
        mag = x[8] ? 9'(-x) : 9'(x);
        p   = '0;
        for (int k = 0; k < 9; k++) begin
            if (mag[k]) begin
                p = 4'(k);
            end
        end
        sh = {23'd0, mag} << (5'd23 - {1'b0, p});
        if (mag == 9'd0) begin
            r = 32'd0;
        end else begin
            r = {x[8], 8'd127 + {4'd0, p}, sh[22:0]};
        end
        return r;
    endfunction

    logic [1:0]  state_reg, state_next;
    logic [3:0]  fmt_reg, fmt_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  elem_reg, elem_next;
    logic [2:0]  slot_reg, slot_next;
    logic        cap_valid_reg;
    logic [2:0]  cap_slot_reg;
    logic [15:0] w_reg [8];
    res_meta_t   meta_reg, meta_next;

    logic        in_req;
    logic        fmt_known;
    logic [8:0]  bc_sum;
    logic [8:0]  n_elems;
    logic [8:0]  rem;
    logic        issue_last;
    logic        wr_en, rd_en, lane_go, out_free;
    logic [15:0] rd_data;
    lane_op_t    lane_op [LANES];
    logic [LANES-1:0]       lane_done;
    logic [LANES-1:0][31:0] lane_res;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_LOAD) && !cfg_valid;
    assign in_req     = s_valid && s_ready;
    assign fmt_known  = fmt_reg <= FMT_F16;
    assign bc_sum     = {1'b0, byte_count_reg} + 9'd2;
    assign n_elems    = blk_elems(fmt_reg);
    assign rem        = n_elems - {1'b0, elem_reg};
    assign issue_last = ({1'b0, elem_reg} + 9'(LANES)) >= n_elems;

    always_comb begin
        state_next      = state_reg;
        fmt_next        = fmt_reg;
        byte_count_next = byte_count_reg;
        elem_next       = elem_reg;
        slot_next       = slot_reg;
        meta_next       = meta_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        lane_go         = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                if (in_req && fmt_known) begin
                    wr_en = 1'b1;
                    if (bc_sum >= blk_bytes(fmt_reg)) begin
                        byte_count_next = 8'd0;
                        elem_next       = 8'd0;
                        slot_next       = 3'd0;
                        state_next      = ST_FETCH;
                    end else begin
                        byte_count_next = bc_sum[7:0];
                    end
                end
            end
            ST_FETCH: begin
                rd_en     = 1'b1;
                slot_next = slot_reg + 3'd1;
                if (slot_reg == 3'd7) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (out_free) begin
                    lane_go                 = 1'b1;
                    meta_next.element_index = elem_reg;
                    meta_next.lanes_valid   = (rem >= 9'(LANES)) ? 3'(LANES) : rem[2:0];
                    meta_next.last          = issue_last;
                    if (issue_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        elem_next  = elem_reg + 8'(LANES);
                        slot_next  = 3'd0;
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
        if (cfg_valid) begin
            fmt_next        = cfg_data;
            byte_count_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            fmt_reg        <= FMT_Q4_0;
            byte_count_reg <= 8'd0;
            elem_reg       <= 8'd0;
            slot_reg       <= 3'd0;
            cap_valid_reg  <= 1'b0;
            meta_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            fmt_reg        <= fmt_next;
            byte_count_reg <= byte_count_next;
            elem_reg       <= elem_next;
            slot_reg       <= slot_next;
            cap_valid_reg  <= rd_en;
            meta_reg       <= meta_next;
        end
    end

    always_ff @(posedge aclk) begin
        cap_slot_reg <= slot_reg;
        if (cap_valid_reg) begin
            w_reg[cap_slot_reg] <= rd_data;
        end
    end

    bqd_store #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .AW              (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(byte_count_reg[7:1])),
        .wr_data ({s_data.byte_hi, s_data.byte_lo}),
        .rd_en   (rd_en),
        .rd_addr (AW'(fetch_addr(fmt_reg, elem_reg, slot_reg))),
        .rd_data (rd_data)
    );

    // per-lane operand forming from the fetched words
    always_comb begin : op_form
        logic [31:0] d_f, m_f;
        logic [31:0] qh32, da, db;
        logic [7:0]  ba, bb, sc;
        logic [3:0]  jj, nib;
        logic        qh_bit;
        logic [1:0]  v2;
        logic [8:0]  x;
        d_f  = half_to_f32(w_reg[0]);
        m_f  = half_to_f32(w_reg[1]);
        qh32 = {w_reg[3], w_reg[2]};
        da   = {w_reg[5], w_reg[4]};
        db   = {w_reg[7], w_reg[6]};
        for (int i = 0; i < LANES; i++) begin
            ba     = da[8*i +: 8];
            bb     = db[8*i +: 8];
            jj     = elem_reg[3:0] + 4'(i);
            nib    = elem_reg[4] ? ba[7:4] : ba[3:0];
            qh_bit = qh32[{elem_reg[4], jj}];
            sc     = elem_reg[4] ? w_reg[6][15:8] : w_reg[6][7:0];
            v2     = 2'((ba >> {elem_reg[6:5], 1'b0}) & 8'h03);
            x      = 9'd0;
            lane_op[i] = '{a: d_f, b: F32_ONE, c: F32_ONE, z1: 32'd0, z2: 32'd0,
                           use_mul2: 1'b0, use_add: 1'b0};
            case (fmt_reg)
                FMT_Q4_0: begin
                    x = {5'd0, nib} - 9'd8;
                    lane_op[i].b = int_to_f32(x);
                end
                FMT_Q4_1: begin
                    x = {5'd0, nib};
                    lane_op[i].b       = int_to_f32(x);
                    lane_op[i].z1      = m_f;
                    lane_op[i].z2      = F32_ONE;
                    lane_op[i].use_add = 1'b1;
                end
                FMT_Q5_0: begin
                    x = {4'd0, qh_bit, nib} - 9'd16;
                    lane_op[i].b = int_to_f32(x);
                end
                FMT_Q5_1: begin
                    x = {4'd0, qh_bit, nib};
                    lane_op[i].b       = int_to_f32(x);
                    lane_op[i].z1      = m_f;
                    lane_op[i].z2      = F32_ONE;
                    lane_op[i].use_add = 1'b1;
                end
                FMT_Q8_0, FMT_Q8_1: begin
                    x = {ba[7], ba};
                    lane_op[i].b = int_to_f32(x);
                end
                FMT_Q2_K: begin
                    lane_op[i].b        = int_to_f32({5'd0, sc[3:0]});
                    lane_op[i].c        = int_to_f32({7'd0, v2});
                    lane_op[i].z1       = {~m_f[31], m_f[30:0]};
                    lane_op[i].z2       = int_to_f32({5'd0, sc[7:4]});
                    lane_op[i].use_mul2 = 1'b1;
                    lane_op[i].use_add  = 1'b1;
                end
                FMT_Q6_K: begin
                    v2 = 2'((bb >> {elem_reg[6:5], 1'b0}) & 8'h03);
                    x  = {3'd0, v2, (elem_reg[6] ? ba[7:4] : ba[3:0])} - 9'd32;
                    lane_op[i].b = elem_reg[4] ? int_to_f32({w_reg[2][15], w_reg[2][15:8]})
                                               : int_to_f32({w_reg[2][7], w_reg[2][7:0]});
                    lane_op[i].c        = int_to_f32(x);
                    lane_op[i].use_mul2 = 1'b1;
                end
                default: begin
                    lane_op[i].b = F32_ONE;
                end
            endcase
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bqd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .go      (lane_go),
            .op      (lane_op[g]),
            .done    (lane_done[g]),
            .res     (lane_res[g])
        );
    end

    bqd_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lane_done (lane_done),
        .lane_res  (lane_res),
        .meta      (meta_reg),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_issue_free: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_go |-> !m_valid)
        else $error("lane issue while output register holds a result");

    a_last_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_go && issue_last |=> state_reg == ST_LOAD)
        else $error("sequencer did not return to intake after last result");

    a_lanes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.lanes_valid != 3'd0 && m_data.lanes_valid <= 3'(LANES))
        else $error("lanes_valid out of range");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, byte_count_reg} < 9'(MAX_BLOCK_BYTES))
        else $error("byte count beyond store");

endmodule
